// ----- hw/rtl/nspe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nspe_pkg
// Shared types and constants of the NRZI stuffed pulse encoder.
// ----------------------------------------------------------------------------
package nspe_pkg;

    localparam int DurationWidth = 15;
    localparam int RunWidth      = 8;
    localparam int ProdWidth     = DurationWidth + RunWidth;
    localparam int MaxPulses     = 8;
    localparam int CountWidth    = $clog2(MaxPulses + 1);
    localparam int IndexWidth    = $clog2(MaxPulses);
    localparam int ApbDataWidth  = 32;
    localparam int ApbAddrWidth  = 3;

    localparam logic [RunWidth-1:0] StuffRun = RunWidth'(6);
    localparam logic [RunWidth-1:0] RunMax   = {RunWidth{1'b1}};
    localparam logic [RunWidth-1:0] RunStart = RunWidth'(1);

    localparam logic [DurationWidth-1:0] UnitReset = DurationWidth'(1);

    typedef enum logic [1:0] {
        OP_BYTE_RAW   = 2'd0,
        OP_BYTE_STUFF = 2'd1,
        OP_END        = 2'd2
    } op_t;

    typedef enum logic {
        REG_MARK_UNIT  = 1'b0,
        REG_SPACE_UNIT = 1'b1
    } reg_idx_t;

    // Pulses found in one request plus the line state it leaves behind.
    typedef struct packed {
        logic [CountWidth-1:0]              count;
        logic [MaxPulses-1:0][RunWidth-1:0] runs;
        logic [MaxPulses-1:0]               levels;
        logic [RunWidth-1:0]                run_next;
        logic                               level_next;
    } scan_t;

endpackage
`default_nettype wire

// ----- hw/rtl/nspe_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nspe_if
// Valid/ready channels of the encoder: byte requests in, pulses out.
// ----------------------------------------------------------------------------
interface nspe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface nspe_out_if;
    logic                               valid;
    logic                               ready;
    logic [nspe_pkg::DurationWidth-1:0] pulse_ticks;
    logic                               pulse_level;
    logic                               last;

    modport source (output valid, output pulse_ticks, output pulse_level, output last,
                    input ready);
    modport sink   (input valid, input pulse_ticks, input pulse_level, input last,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/nspe_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nspe_scan
// Walk the eight bits of one request and list the runs it closes.
// ----------------------------------------------------------------------------
module nspe_scan
(
    input  wire logic [1:0]                      operation,
    input  wire logic [7:0]                      data_byte,
    input  wire logic [nspe_pkg::RunWidth-1:0]   run_in,
    input  wire logic                            level_in,
    output nspe_pkg::scan_t                      scan
);

    logic [nspe_pkg::RunWidth-1:0]   run;
    logic                            lvl;
    logic [nspe_pkg::CountWidth-1:0] cnt;
    logic                            stuff;
    logic                            close;

    always_comb
    begin
        run        = run_in;
        lvl        = level_in;
        cnt        = '0;
        stuff      = 1'b0;
        close      = 1'b0;
        scan.runs   = '0;
        scan.levels = '0;
        case (nspe_pkg::op_t'(operation))
            nspe_pkg::OP_END:
            begin
                // zero-length marker pulse, line back to idle high
                cnt = nspe_pkg::CountWidth'(1);
                run = nspe_pkg::RunStart;
                lvl = 1'b1;
            end
            nspe_pkg::OP_BYTE_RAW, nspe_pkg::OP_BYTE_STUFF:
            begin
                stuff = (operation == nspe_pkg::OP_BYTE_STUFF);
                for (int b = 0; b < 8; b++)
                begin
                    close = 1'b0;
                    if (data_byte[b])
                    begin
                        if (run != nspe_pkg::RunMax)
                            run = run + nspe_pkg::RunWidth'(1);
                        close = stuff && (run >= nspe_pkg::StuffRun);
                    end
                    else
                    begin
                        close = 1'b1;
                    end
                    if (close)
                    begin
                        scan.runs[cnt[nspe_pkg::IndexWidth-1:0]]   = run;
                        scan.levels[cnt[nspe_pkg::IndexWidth-1:0]] = lvl;
                        cnt = cnt + nspe_pkg::CountWidth'(1);
                        run = nspe_pkg::RunStart;
                        lvl = ~lvl;
                    end
                end
            end
            default:
            begin
                // unused code: no pulse, state untouched
            end
        endcase
        scan.count      = cnt;
        scan.run_next   = run;
        scan.level_next = lvl;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nrzi_stuffed_pulse_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrzi_stuffed_pulse_encoder
// Bytes in, LSb first; run-length NRZI pulses out, with optional HDLC
// bit stuffing and per-level tick units.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  -------   ---  ---------          -------
//  in_ch     in   valid / ready      operation[1:0], data_byte[7:0]
//  out_ch    out  valid / ready      pulse_ticks[14:0], pulse_level, last
//  apb       in   psel/penable/...   mark_unit @ 0x0, space_unit @ 0x4
//
//  A request is scanned in the cycle it is accepted; its pulses (0 to 8)
//  then leave one per cycle, while out_ch is not stalled, through the
//  output register. The pulse buffer holds them: the next request is
//  taken in the cycle the last buffered pulse moves out. A request that
//  closes no run yields nothing.
//  Reset clears the line to level high, run 1, and both units to 1.
//  A stall on out_ch holds the output register and the buffer in place.
//
// ----------------------------------------------------------------------------
module nrzi_stuffed_pulse_encoder
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    nspe_in_if.sink                                  in_ch,
    nspe_out_if.source                               out_ch,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nspe_pkg::ApbAddrWidth-1:0]   paddr,
    input  wire logic [nspe_pkg::ApbDataWidth-1:0]   pwdata,
    output logic      [nspe_pkg::ApbDataWidth-1:0]   prdata,
    output logic                                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [nspe_pkg::DurationWidth-1:0] mark_reg;
    logic [nspe_pkg::DurationWidth-1:0] space_reg;
    logic                               cfg_write;
    nspe_pkg::reg_idx_t                 cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // word aligned: address bit 2 picks the register
    assign cfg_sel   = nspe_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= nspe_pkg::UnitReset;
            space_reg <= nspe_pkg::UnitReset;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                nspe_pkg::REG_MARK_UNIT:
                    mark_reg <= pwdata[nspe_pkg::DurationWidth-1:0];
                nspe_pkg::REG_SPACE_UNIT:
                    space_reg <= pwdata[nspe_pkg::DurationWidth-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            nspe_pkg::REG_MARK_UNIT:
                prdata = nspe_pkg::ApbDataWidth'(mark_reg);
            nspe_pkg::REG_SPACE_UNIT:
                prdata = nspe_pkg::ApbDataWidth'(space_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Line state and request scan
    // ------------------------------------------------------------------
    logic [nspe_pkg::RunWidth-1:0] run_reg;
    logic                          level_reg;
    nspe_pkg::scan_t               scan;

    nspe_scan u_scan
    (
        .operation (in_ch.operation),
        .data_byte (in_ch.data_byte),
        .run_in    (run_reg),
        .level_in  (level_reg),
        .scan      (scan)
    );

    // ------------------------------------------------------------------
    // Pulse buffer: runs and levels of the request in flight
    // ------------------------------------------------------------------
    logic [nspe_pkg::MaxPulses-1:0][nspe_pkg::RunWidth-1:0] runs_reg;
    logic [nspe_pkg::MaxPulses-1:0]                         levels_reg;
    logic [nspe_pkg::CountWidth-1:0]                        left_reg;
    logic [nspe_pkg::IndexWidth-1:0]                        idx_reg;

    logic pending;
    logic emit;
    logic emit_last;
    logic accept;

    logic                               out_valid_reg;
    logic [nspe_pkg::DurationWidth-1:0] ticks_reg;
    logic                               out_level_reg;
    logic                               last_reg;

    assign pending   = (left_reg != '0);
    // move a pulse out when the output register is free or draining
    assign emit      = pending && (!out_valid_reg || out_ch.ready);
    assign emit_last = emit && (left_reg == nspe_pkg::CountWidth'(1));
    assign in_ch.ready = !pending || emit_last;
    assign accept    = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= nspe_pkg::RunStart;
            level_reg <= 1'b1;
            left_reg  <= '0;
            idx_reg   <= '0;
        end
        else if (accept)
        begin
            run_reg   <= scan.run_next;
            level_reg <= scan.level_next;
            left_reg  <= scan.count;
            idx_reg   <= '0;
        end
        else if (emit)
        begin
            left_reg <= left_reg - nspe_pkg::CountWidth'(1);
            idx_reg  <= idx_reg + nspe_pkg::IndexWidth'(1);
        end
    end

    // payload of the buffer, loaded with each request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            runs_reg   <= scan.runs;
            levels_reg <= scan.levels;
        end
    end

    // ------------------------------------------------------------------
    // Duration: run length times the unit of the pulse's level, saturated
    // ------------------------------------------------------------------
    logic                               cur_level;
    logic [nspe_pkg::DurationWidth-1:0] cur_unit;
    logic [nspe_pkg::ProdWidth-1:0]     product;
    logic [nspe_pkg::DurationWidth-1:0] ticks_next;

    assign cur_level = levels_reg[idx_reg];
    assign cur_unit  = cur_level ? mark_reg : space_reg;
    assign product   = nspe_pkg::ProdWidth'(cur_unit) * nspe_pkg::ProdWidth'(runs_reg[idx_reg]);

    always_comb
    begin
        if (|product[nspe_pkg::ProdWidth-1:nspe_pkg::DurationWidth])
            ticks_next = {nspe_pkg::DurationWidth{1'b1}};
        else
            ticks_next = product[nspe_pkg::DurationWidth-1:0];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ticks_reg     <= ticks_next;
            out_level_reg <= cur_level;
            last_reg      <= (left_reg == nspe_pkg::CountWidth'(1));
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pulse_ticks = ticks_reg;
    assign out_ch.pulse_level = out_level_reg;
    assign out_ch.last        = last_reg;

endmodule
`default_nettype wire

// ----- sim/tb_nrzi_stuffed_pulse_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nrzi_stuffed_pulse_encoder
// Self-checking bench for the NRZI stuffed pulse encoder. A short table of
// directed requests runs first. Well-formed frames with random content
// follow, mixed with long runs of ones and random noise, under several
// settings of the mark and space units. Every pulse is checked against a
// built-in line-state predictor, or against its own row where a directed row is typed.
// ----------------------------------------------------------------------------
module tb_nrzi_stuffed_pulse_encoder;
    import nspe_pkg::*;

    // Operation code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int          WaitMax       = 8;
    localparam int          DrainLimit    = 2000;
    localparam int          SettleCycles  = 10;
    localparam int          Phases        = 6;
    localparam int unsigned PhaseRequests = 80;
    localparam int unsigned ReportMax     = 10;
    localparam logic [7:0]  FLAG_BYTE     = 8'h7E;

    localparam logic [DurationWidth-1:0] TicksMax = '1;

    typedef struct packed {
        logic [DurationWidth-1:0] ticks;
        logic                     level;
        logic                     last;
    } pulse_t;

    // One directed request. Where typed is set, the row carries its own
    // expectation: exactly one pulse if typed_pulse is set, else none.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       typed;
        logic       typed_pulse;
        pulse_t     pulse;
    } directed_row_t;

    localparam pulse_t NoPulse  = '0;
    localparam pulse_t EndPulse = '{ticks: '0, level: 1'b0, last: 1'b1};
    localparam pulse_t Run8High = '{ticks: DurationWidth'(8), level: 1'b1, last: 1'b1};

    // Directed requests, all under the reset units of 1 tick per bit.
    localparam int DirectedRows = 23;
    localparam directed_row_t DIRECTED_ROWS [DirectedRows] = '{
        '{OP_BYTE_RAW,   8'hFF, 1'b1, 1'b0, NoPulse},   // all ones: no run closes
        '{OP_UNUSED,     8'h00, 1'b1, 1'b0, NoPulse},   // unused operation
        '{OP_BYTE_STUFF, 8'h01, 1'b0, 1'b0, NoPulse},   // long raw run, then stuffing
        '{OP_END,        8'h00, 1'b1, 1'b1, EndPulse},
        '{OP_BYTE_RAW,   8'h7F, 1'b1, 1'b1, Run8High},  // seven ones and a zero
        '{OP_END,        8'hFF, 1'b1, 1'b1, EndPulse},
        '{OP_BYTE_RAW,   8'h00, 1'b0, 1'b0, NoPulse},   // eight pulses from one byte
        '{OP_BYTE_STUFF, 8'hFF, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'h00, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_RAW,   8'h7E, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'h3F, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'hFC, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_RAW,   8'h7E, 1'b0, 1'b0, NoPulse},
        '{OP_END,        8'h5A, 1'b1, 1'b1, EndPulse},
        '{OP_BYTE_RAW,   8'h80, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_RAW,   8'h55, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'hAA, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'h1F, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'hF8, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_RAW,   8'hFF, 1'b0, 1'b0, NoPulse},
        '{OP_BYTE_STUFF, 8'hFF, 1'b0, 1'b0, NoPulse},
        '{OP_UNUSED,     8'hFF, 1'b1, 1'b0, NoPulse},
        '{OP_END,        8'h00, 1'b1, 1'b1, EndPulse}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ApbAddrWidth-1:0] paddr;
    logic [ApbDataWidth-1:0] pwdata;
    logic [ApbDataWidth-1:0] prdata;
    logic                    pready;

    nspe_in_if  in_ch ();
    nspe_out_if out_ch ();

    nrzi_stuffed_pulse_encoder DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predicted line state and units, kept in step with every accepted
    // request and every register write.
    // ------------------------------------------------------------------
    logic [DurationWidth-1:0] mark_ticks;
    logic [DurationWidth-1:0] space_ticks;
    logic [RunWidth-1:0]      run_len;
    logic                     line_high;

    pulse_t expected_pulses [$];    // pulses still owed by the block, oldest first
    pulse_t scan_pulses [$];        // pulses of the request just accepted

    bit          source_idles;
    bit          sink_idles;
    int unsigned requests_sent;
    int unsigned ignored_sent;
    int unsigned frames_sent;
    int unsigned pulses_seen;
    int unsigned failures;

    // Walk one request bit by bit and collect the pulses it closes.
    function void encode_request(input logic [1:0] op, input logic [7:0] data);
        pulse_t               found [MaxPulses];
        int                   n;
        logic [ProdWidth-1:0] prod;
        logic                 stuffing;
        scan_pulses.delete();
        n = 0;
        stuffing = (op == OP_BYTE_STUFF);
        if (op == OP_END)
        begin
            // Zero-length marker, then restart the line idle high
            scan_pulses.push_back(EndPulse);
            run_len = RunStart;
            line_high = 1'b1;
        end
        else if (op != OP_UNUSED)
        begin
            for (int b = 0; b < 8; b++)
            begin
                // A one extends the run, saturating rather than wrapping
                if (data[b] && run_len != RunMax)
                    run_len = run_len + 1'b1;
                // A zero closes the run; so does a stuffed zero after five ones
                if (!data[b] || (stuffing && run_len >= StuffRun))
                begin
                    prod = ProdWidth'(line_high ? mark_ticks : space_ticks)
                         * ProdWidth'(run_len);
                    found[n].ticks = (prod > ProdWidth'(TicksMax)) ? TicksMax
                                                                   : prod[DurationWidth-1:0];
                    found[n].level = line_high;
                    found[n].last  = 1'b0;
                    n++;
                    run_len = RunStart;
                    line_high = ~line_high;
                end
            end
            for (int k = 0; k < n; k++)
            begin
                if (k == n - 1)
                    found[k].last = 1'b1;
                scan_pulses.push_back(found[k]);
            end
        end
    endfunction

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, WaitMax) : 0;
    endfunction

    task automatic report_failure(input string what);
        failures++;
        if (failures <= ReportMax)
            $display("%s", what);
    endtask

    // ------------------------------------------------------------------
    // Request side: idle for a drawn gap, present the request, hold it
    // until accepted, then log what the block now owes.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic [7:0] data,
                                input logic typed = 1'b0, input logic typed_pulse = 1'b0,
                                input pulse_t pulse = NoPulse);
        int unsigned gap;
        gap = draw_wait(source_idles);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= data;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        // Advance the predictor even where the row types its own expectation
        encode_request(op, data);
        if (typed)
        begin
            if (typed_pulse)
                expected_pulses.push_back(pulse);
        end
        else
        begin
            foreach (scan_pulses[k])
                expected_pulses.push_back(scan_pulses[k]);
        end
        if (op == OP_UNUSED)
            ignored_sent++;
        else
            requests_sent++;
    endtask

    // Drop valid and hold off until every owed pulse has arrived or the drain limit
    // runs out, then let the block finish any request that closed no run.
    task automatic drain_pulses();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_pulses.size() != 0 && waited < DrainLimit)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, access cycle, done when pready is high.
    task automatic apb_transfer(input reg_idx_t idx, input logic write,
                                input logic [ApbDataWidth-1:0] wdata,
                                output logic [ApbDataWidth-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ApbAddrWidth'(4 * int'(idx));
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a unit with junk in the unused upper bits, read it back, and
    // update the predictor.
    task automatic set_unit(input reg_idx_t idx, input logic [DurationWidth-1:0] value);
        logic [ApbDataWidth-1:0] wdata;
        logic [ApbDataWidth-1:0] rdata;
        wdata = $urandom;
        wdata[DurationWidth-1:0] = value;
        apb_transfer(idx, 1'b1, wdata, rdata);
        apb_transfer(idx, 1'b0, '0, rdata);
        if (rdata !== ApbDataWidth'(value))
            report_failure($sformatf("readback of %s: expected 0x%0h, got 0x%0h",
                                     idx.name(), value, rdata));
        case (idx)
            REG_MARK_UNIT:  mark_ticks  = value;
            REG_SPACE_UNIT: space_ticks = value;
            default:        ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run far beyond the slowest legal pace: every request with
    // eight pulses, each pulse stalled to the limit.
    initial
    begin : watchdog
        #5ms;
        $display("tb_nrzi_stuffed_pulse_encoder failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Pulse side: stall for a drawn number of cycles, then hold ready
    // until a pulse is taken and compare it with the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : pulse_sink
        pulse_t      want;
        pulse_t      got;
        int unsigned stall;
        forever
        begin
            stall = draw_wait(sink_idles);
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            got = '{ticks: out_ch.pulse_ticks, level: out_ch.pulse_level, last: out_ch.last};
            pulses_seen++;
            if (expected_pulses.size() == 0)
                report_failure($sformatf("unexpected pulse: ticks %0d level %0b last %0b",
                                         got.ticks, got.level, got.last));
            else
            begin
                want = expected_pulses.pop_front();
                if (got.ticks !== want.ticks || got.level !== want.level
                    || got.last !== want.last)
                    report_failure($sformatf(
                        "pulse %0d: expected ticks/level/last %0d/%0b/%0b, got %0d/%0b/%0b",
                        pulses_seen, want.ticks, want.level, want.last,
                        got.ticks, got.level, got.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [DurationWidth-1:0] mark_plan  [Phases];
        logic [DurationWidth-1:0] space_plan [Phases];
        directed_row_t            row;
        int unsigned              phase_start;
        int unsigned              kind;
        logic [7:0]               body;

        // Hold every input at a known value from time zero
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_BYTE_RAW;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        mark_ticks   = UnitReset;
        space_ticks  = UnitReset;
        run_len      = RunStart;
        line_high    = 1'b1;
        source_idles = 1'b1;
        sink_idles   = 1'b1;

        // Assert reset, release it away from the clock edge
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table under the reset units
        for (int i = 0; i < DirectedRows; i++)
        begin
            row = DIRECTED_ROWS[i];
            send_request(row.op, row.data, row.typed, row.typed_pulse, row.pulse);
        end
        drain_pulses();

        // Unit settings per phase: both extremes, mixed extremes, a zero unit
        // on either side (the other unit 9 or random), and unity.
        mark_plan  = '{TicksMax, DurationWidth'(1), TicksMax, '0,
                       DurationWidth'($urandom_range(2, 300)), DurationWidth'(1)};
        space_plan = '{TicksMax, TicksMax, DurationWidth'(1), DurationWidth'(9),
                       '0, DurationWidth'(1)};

        for (int p = 0; p < Phases; p++)
        begin
            // Rotate idling: both sides, sender only, receiver only, neither
            source_idles = (p % 4 == 0) || (p % 4 == 1);
            sink_idles   = (p % 4 == 0) || (p % 4 == 2);
            set_unit(REG_MARK_UNIT, mark_plan[p]);
            set_unit(REG_SPACE_UNIT, space_plan[p]);

            phase_start = requests_sent;
            while (requests_sent - phase_start < PhaseRequests)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    // Well-formed frame: opening flags, stuffed body, closing flag, end
                    repeat ($urandom_range(1, 2)) send_request(OP_BYTE_RAW, FLAG_BYTE);
                    repeat ($urandom_range(1, 6))
                    begin
                        body = $urandom;
                        // Bias some bytes toward long runs of ones to force stuffing
                        if ($urandom_range(0, 3) == 0)
                            body = body | (8'h3F << $urandom_range(0, 2));
                        send_request(OP_BYTE_STUFF, body);
                    end
                    send_request(OP_BYTE_RAW, FLAG_BYTE);
                    send_request(OP_END, 8'($urandom));
                    frames_sent++;
                end
                else if (kind == 6)
                begin
                    // Long unbroken run: push the run counter into saturation
                    repeat ($urandom_range(32, 40)) send_request(OP_BYTE_RAW, 8'hFF);
                    send_request($urandom_range(0, 1) ? OP_BYTE_STUFF : OP_BYTE_RAW,
                                 8'($urandom));
                end
                else
                begin
                    // Noise: any operation, any byte, broken frames included
                    repeat ($urandom_range(1, 4)) send_request(2'($urandom), 8'($urandom));
                end
                // Now and then hold the sender until the block has caught up
                if ($urandom_range(0, 11) == 0)
                    drain_pulses();
            end
            drain_pulses();
        end

        if (expected_pulses.size() != 0)
            report_failure($sformatf("%0d pulses never arrived", expected_pulses.size()));

        $display("Covered %0d requests (%0d ignored), %0d frames, %0d pulses, %0d unit sets",
                 requests_sent, ignored_sent, frames_sent, pulses_seen, Phases + 1);
        $display("Failures: %0d", failures);
        if (failures == 0)
            $display("tb_nrzi_stuffed_pulse_encoder passed");
        else
            $display("tb_nrzi_stuffed_pulse_encoder failed");
        $finish;
    end

endmodule
